// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clock and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion label failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion label failed");

`endif

// File: src/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// types and constants shared by the scalar kalman filter modules
// ----------------------------------------------------------------------------
package skf_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int DATA_WIDTH = 32;
   localparam int NOISE_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [31:0] RESET_ERROR = 32'd2508800;
   localparam logic [15:0] RESET_NOISE = 16'd10;

   // restoring divider: one quotient bit per step, gain saturates at bit 16
   localparam int DIV_STEPS = 17;
   localparam int DIV_COUNT_WIDTH = $clog2(DIV_STEPS);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MEAS_ERROR    = 2'd0,
      CSR_PROCESS_NOISE = 2'd1,
      CSR_INITIAL_ERROR = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_DELTA = 2'd0,
      MUL_KEEP  = 2'd1,
      MUL_NOISE = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_step;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        chg_load;
      logic        keep_load;
      logic        commit;
   } cmd_type;

endpackage

// File: src/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// one-dimensional kalman smoother with adaptive error for sensor samples
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   req_sample
//  rsp       out        rsp_valid/rsp_stall   rsp_estimate, rsp_error_level
//  csr       in         csr_write             csr_index, csr_data
//
//  an item passes from transfer to result through 17 steps of the restoring
//  gain divider, 3 passes through the shared multiplier and a commit
//  the next item is taken the cycle after the result is registered
//  the result stays in its register under rsp_stall but for a write of the
//  initial error; the commit of a later item waits until that register is free
//  synchronous reset loads the register defaults and the starting error
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scalar_kalman_filter #(
   parameter int SAMPLE_WIDTH = skf_pkg::SAMPLE_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [31:0]                   rsp_estimate,
   output logic [31:0]                          rsp_error_level,
   input  logic                                 csr_write,
   input  logic [skf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [31:0]                          csr_data
);

   skf_pkg::cmd_type cmd;
   logic             state_touch;
   logic [63:0]      rsp_result;

   skf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   skf_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sample      (req_sample),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .estimate    (rsp_estimate),
      .error_level (rsp_error_level)
   );

   // anything that may move the result register
   assign state_touch = reset || cmd.commit || csr_write;
   assign rsp_result  = {rsp_estimate, rsp_error_level};

   `ASSERT_NEXT(busy_after_transfer, req_valid && !req_stall, req_stall)
   `ASSERT_NEXT(valid_after_commit, cmd.commit, rsp_valid)
   `ASSERT_IMPLY(rise_needs_commit, $rose(rsp_valid), $past(cmd.commit))
   `ASSERT_IMPLY(result_holds, !$past(state_touch), $stable(rsp_result))

endmodule

// File: src/skf_ctrl.sv
// ----------------------------------------------------------------------------
// skf_ctrl
// sequencer for one filter update: divide, three multiplies, commit
// ----------------------------------------------------------------------------
module skf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output skf_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL_DELTA,
      ST_MUL_KEEP,
      ST_MUL_NOISE,
      ST_FINISH
   } state_type;

   state_type                             state_ff, state_in;
   logic [skf_pkg::DIV_COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd          = '0;
      cmd.mul_sel  = skf_pkg::MUL_DELTA;
      case (state_ff)
         ST_IDLE: begin
            count_in = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == skf_pkg::DIV_COUNT_WIDTH'(skf_pkg::DIV_STEPS - 1)) begin
               state_in = ST_MUL_DELTA;
            end
         end
         ST_MUL_DELTA: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = skf_pkg::MUL_DELTA;
            state_in    = ST_MUL_KEEP;
         end
         ST_MUL_KEEP: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = skf_pkg::MUL_KEEP;
            cmd.chg_load = 1'b1;
            state_in     = ST_MUL_NOISE;
         end
         ST_MUL_NOISE: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = skf_pkg::MUL_NOISE;
            cmd.keep_load = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/skf_dp.sv
// ----------------------------------------------------------------------------
// skf_dp
// filter datapath: settings, state, gain divider and shared multiplier
// ----------------------------------------------------------------------------
module skf_dp #(
   parameter int SAMPLE_WIDTH = skf_pkg::SAMPLE_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  skf_pkg::cmd_type                     cmd,
   input  logic signed [SAMPLE_WIDTH-1:0]       sample,
   input  logic                                 csr_write,
   input  logic [skf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [31:0]                          csr_data,
   output logic signed [31:0]                   estimate,
   output logic [31:0]                          error_level
);

   localparam int MeasW = SAMPLE_WIDTH + 16;

   logic [31:0]        meas_error_ff;
   logic [15:0]        noise_ff;
   logic signed [31:0] last_ff, last_in;
   logic [31:0]        error_ff, error_in;

   logic [31:0]        meas_ff;
   logic [33:0]        rem_ff;
   logic [32:0]        den_ff;
   logic [16:0]        quo_ff;
   logic               zero_den_ff;
   logic [32:0]        diff_mag_ff;
   logic               neg_ff;
   logic [49:0]        prod_ff;
   logic [31:0]        chg_ff;
   logic [31:0]        keep_ff;

   logic [MeasW-1:0]   meas_wide;
   logic [MeasW+31:0]  meas_ext;
   logic [MeasW:0]     meas_top;
   logic [31:0]        meas_sat;
   logic [32:0]        den_sum;
   logic [33:0]        trial;
   logic               quo_bit;
   logic [32:0]        rem_keep;
   logic [32:0]        diff;
   logic [15:0]        gain;
   logic [32:0]        mul_a;
   logic [16:0]        mul_b;
   logic [49:0]        mul_prod;
   logic [32:0]        delta;
   logic [32:0]        est_sum;
   logic [40:0]        err_sum;

   // scaled measurement, clamped to q16.16
   assign meas_wide = {sample, 16'b0};
   assign meas_ext  = {{32{meas_wide[MeasW-1]}}, meas_wide};
   assign meas_top  = meas_ext[MeasW+31:31];
   always_comb begin
      if ((&meas_top) || !(|meas_top)) begin
         meas_sat = meas_ext[31:0];
      end else if (meas_wide[MeasW-1]) begin
         meas_sat = 32'h8000_0000;
      end else begin
         meas_sat = 32'h7FFF_FFFF;
      end
   end

   assign den_sum = {1'b0, error_ff} + {1'b0, meas_error_ff};

   // restoring divide step
   assign trial    = rem_ff - {1'b0, den_ff};
   assign quo_bit  = !trial[33];
   assign rem_keep = quo_bit ? trial[32:0] : rem_ff[32:0];

   assign diff = {meas_ff[31], meas_ff} - {last_ff[31], last_ff};

   always_comb begin
      if (zero_den_ff) begin
         gain = '0;
      end else if (quo_ff[16]) begin
         gain = 16'hFFFF;
      end else begin
         gain = quo_ff[15:0];
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         skf_pkg::MUL_DELTA: begin
            mul_a = diff_mag_ff;
            mul_b = {1'b0, gain};
         end
         skf_pkg::MUL_KEEP: begin
            mul_a = {1'b0, error_ff};
            mul_b = 17'h1_0000 - {1'b0, gain};
         end
         skf_pkg::MUL_NOISE: begin
            mul_a = {1'b0, chg_ff};
            mul_b = {1'b0, noise_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod = {17'b0, mul_a} * {33'b0, mul_b};

   assign delta   = neg_ff ? (33'd0 - {1'b0, chg_ff}) : {1'b0, chg_ff};
   assign est_sum = {last_ff[31], last_ff} + delta;
   assign err_sum = {9'b0, keep_ff} + {1'b0, prod_ff[47:8]};

   always_comb begin
      last_in  = last_ff;
      error_in = error_ff;
      if (csr_write && (csr_index == skf_pkg::CSR_INITIAL_ERROR)) begin
         last_in  = '0;
         error_in = csr_data;
      end else if (cmd.commit) begin
         last_in  = est_sum[31:0];
         error_in = (|err_sum[40:32]) ? 32'hFFFF_FFFF : err_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meas_error_ff <= skf_pkg::RESET_ERROR;
         noise_ff      <= skf_pkg::RESET_NOISE;
         last_ff       <= '0;
         error_ff      <= skf_pkg::RESET_ERROR;
      end else begin
         if (csr_write && (csr_index == skf_pkg::CSR_MEAS_ERROR)) begin
            meas_error_ff <= csr_data;
         end
         if (csr_write && (csr_index == skf_pkg::CSR_PROCESS_NOISE)) begin
            noise_ff <= csr_data[15:0];
         end
         last_ff  <= last_in;
         error_ff <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         meas_ff     <= meas_sat;
         rem_ff      <= {2'b0, error_ff};
         den_ff      <= den_sum;
         zero_den_ff <= (den_sum == '0);
         quo_ff      <= '0;
      end
      if (cmd.div_step) begin
         rem_ff      <= {rem_keep, 1'b0};
         quo_ff      <= {quo_ff[15:0], quo_bit};
         neg_ff      <= diff[32];
         diff_mag_ff <= diff[32] ? (33'd0 - diff) : diff;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_prod;
      end
      if (cmd.chg_load) begin
         chg_ff <= prod_ff[47:16];
      end
      if (cmd.keep_load) begin
         keep_ff <= prod_ff[47:16];
      end
   end

   assign estimate    = last_ff;
   assign error_level = error_ff;

endmodule
